[rtl/spq_pkg.sv]
// Package with shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int VALUE_W          = 32;
   localparam int STATUS_W         = 2;
   localparam int OCC_W            = 5;

   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                      enq;
      logic                      deq;
      logic signed [VALUE_W-1:0] value;
   } spq_cmd_type;

endpackage
`default_nettype wire

[rtl/spq_cell.sv]
// One storage cell of the sorted chain, holding a single value.
`default_nettype none
module spq_cell (
   input  wire logic                              clock,
   input  wire spq_pkg::spq_cmd_type              cmd,
   input  wire logic                              occupied,
   input  wire logic                              at_tail,
   input  wire logic                              left_place,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] left_value,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] right_value,
   output logic                                   place,
   output logic signed [spq_pkg::VALUE_W-1:0]      value
);

   logic signed [spq_pkg::VALUE_W-1:0] value_ff;
   logic signed [spq_pkg::VALUE_W-1:0] value_in;
   logic                               ge;

   assign ge    = occupied && (value_ff >= cmd.value);
   assign place = ge || at_tail;
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.enq) begin
         if (left_place) begin
            value_in = left_value;
         end else if (place) begin
            value_in = cmd.value;
         end
      end else if (cmd.deq) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

[rtl/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue built as a chain of cells.
// A result appears in the cycle after its request transfer.
// One request is taken every cycle while the result register is free or drained.
// Each cell compares itself with the new value in parallel, so insert and removal take one step.
// Reset clears the count and the result valid flag; cell contents are not cleared.
`default_nettype none
module sorted_priority_queue_unit #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_kind,
   input  wire logic signed [spq_pkg::VALUE_W-1:0]  req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [spq_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic                                     rsp_out_valid,
   output logic [spq_pkg::STATUS_W-1:0]             rsp_status,
   output logic [spq_pkg::OCC_W-1:0]                rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic signed [spq_pkg::VALUE_W-1:0]  out_value_ff;
   logic signed [spq_pkg::VALUE_W-1:0]  out_value_in;
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [spq_pkg::STATUS_W-1:0]        status_ff;
   logic [spq_pkg::STATUS_W-1:0]        status_in;
   logic [spq_pkg::OCC_W-1:0]           occ_ff;
   logic [spq_pkg::OCC_W-1:0]           occ_in;

   logic                                accept;
   logic                                full;
   logic                                empty;
   spq_pkg::spq_cmd_type                cmd;
   logic                                cell_place [CAPACITY];
   logic signed [spq_pkg::VALUE_W-1:0]  cell_value [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign cmd.enq   = accept && (req_kind == spq_pkg::KIND_ENQ) && !full;
   assign cmd.deq   = accept && (req_kind == spq_pkg::KIND_DEQ) && !empty;
   assign cmd.value = req_value;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                               left_place;
         logic signed [spq_pkg::VALUE_W-1:0] left_value;
         logic signed [spq_pkg::VALUE_W-1:0] right_value;

         if (i == 0) begin : g_head
            assign left_place = 1'b0;
            assign left_value = '0;
         end else begin : g_body
            assign left_place = cell_place[i-1];
            assign left_value = cell_value[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
         end else begin : g_inner
            assign right_value = cell_value[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .occupied    (CNT_W'(i) < count_ff),
            .at_tail     (CNT_W'(i) == count_ff),
            .left_place  (left_place),
            .left_value  (left_value),
            .right_value (right_value),
            .place       (cell_place[i]),
            .value       (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      out_value_in = out_value_ff;
      out_valid_in = out_valid_ff;
      status_in    = status_ff;
      occ_in       = occ_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_value_in = '0;
         out_valid_in = 1'b0;
         status_in    = spq_pkg::STATUS_OK;
         if (req_kind == spq_pkg::KIND_ENQ) begin
            if (full) begin
               status_in = spq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (empty) begin
               status_in = spq_pkg::STATUS_EMPTY;
            end else begin
               count_in     = count_ff - CNT_W'(1);
               out_value_in = cell_value[0];
               out_valid_in = 1'b1;
            end
         end
         occ_in = spq_pkg::OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_valid_ff <= out_valid_in;
      status_ff    <= status_in;
      occ_ff       <= occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Queue count exceeds capacity.");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.enq |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("Accepted insert did not raise the count.");

   a_deq_result: assert property (@(posedge clock) disable iff (reset)
      cmd.deq |=> rsp_valid && rsp_out_valid && rsp_status == spq_pkg::STATUS_OK)
      else $error("Removal did not produce a valid value.");

   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |-> rsp_status == spq_pkg::STATUS_OK)
      else $error("Returned value carries an error status.");

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the sorted priority queue unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY       = spq_pkg::CAPACITY_DEFAULT;
   localparam int RSP_HOLD_LEN   = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_TARGET  = 1300;
   localparam int CALM_TAIL      = 150;
   localparam int HOLD_AT        = 400;
   localparam int DRAIN_AT_A     = 600;
   localparam int DRAIN_AT_B     = 1000;

   typedef struct packed {
      logic                               kind;
      logic signed [spq_pkg::VALUE_W-1:0] value;
      logic                               drain_first;
      logic                               hold_rsp;
   } queue_req_type;

   typedef struct packed {
      logic signed [spq_pkg::VALUE_W-1:0] out_value;
      logic                               out_valid;
      logic [spq_pkg::STATUS_W-1:0]       status;
      logic [spq_pkg::OCC_W-1:0]          occupancy;
   } queue_rsp_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_kind = spq_pkg::KIND_ENQ;
   logic signed [spq_pkg::VALUE_W-1:0] req_value = '0;
   logic                               req_hold = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [spq_pkg::VALUE_W-1:0] rsp_out_value;
   logic                               rsp_out_valid;
   logic [spq_pkg::STATUS_W-1:0]       rsp_status;
   logic [spq_pkg::OCC_W-1:0]          rsp_occupancy;

   queue_req_type                      pending_reqs[$];
   queue_rsp_type                      awaited_rsps[$];
   logic signed [spq_pkg::VALUE_W-1:0] sorted_vals[CAPACITY];
   int                                 sorted_count = 0;

   bit                                 req_taken = 1'b0;
   int                                 error_count = 0;
   int                                 idle_cycles = 0;
   int                                 hold_asked = 0;
   int                                 hold_served = 0;
   int                                 send_gap = 0;
   int                                 recv_gap = 0;
   int                                 recv_hold = 0;
   queue_req_type                      next_req;
   queue_rsp_type                      want;
   bit                                 any_transfer;

   sorted_priority_queue_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_value (rsp_out_value),
      .rsp_out_valid (rsp_out_valid),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic queue_rsp_type sorted_list_step(
      input logic                               kind,
      input logic signed [spq_pkg::VALUE_W-1:0] value);
      queue_rsp_type r;
      int            pos;
      int            i;
      r = '0;
      if (kind == spq_pkg::KIND_ENQ) begin
         if (sorted_count >= CAPACITY) begin
            r.status = spq_pkg::STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < sorted_count && sorted_vals[pos] < value) pos++;
            for (i = sorted_count; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
            sorted_vals[pos] = value;
            sorted_count++;
            r.status = spq_pkg::STATUS_OK;
         end
      end else if (sorted_count == 0) begin
         r.status = spq_pkg::STATUS_EMPTY;
      end else begin
         r.out_value = sorted_vals[0];
         r.out_valid = 1'b1;
         r.status    = spq_pkg::STATUS_OK;
         for (i = 1; i < sorted_count; i++) sorted_vals[i-1] = sorted_vals[i];
         sorted_count--;
      end
      r.occupancy = sorted_count[spq_pkg::OCC_W-1:0];
      return r;
   endfunction

   function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
      logic signed [spq_pkg::VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = $urandom;
         5, 6, 7:       v = $signed($urandom_range(0, 8)) - 4;
         8: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7fff_ffff;
               2:       v = 0;
               default: v = -1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1) == 0) v = 32'sh8000_0000 + $urandom_range(0, 3);
            else v = 32'sh7fff_ffff - $urandom_range(0, 3);
         end
      endcase
      return v;
   endfunction

   task automatic add_req(input logic kind,
                          input logic signed [spq_pkg::VALUE_W-1:0] value);
      queue_req_type item;
      item.kind        = kind;
      item.value       = value;
      item.hold_rsp    = (pending_reqs.size() == HOLD_AT);
      item.drain_first = (pending_reqs.size() == DRAIN_AT_A ||
                          pending_reqs.size() == DRAIN_AT_B);
      pending_reqs.push_back(item);
   endtask

   // Sender: offers the next queued request at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain_first && awaited_rsps.size() != 0)) begin
         req_valid <= 1'b0;
      end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
         send_gap = $urandom_range(1, 12) - 1;
         req_valid <= 1'b0;
      end else begin
         next_req = pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_kind  <= next_req.kind;
         req_value <= next_req.value;
         req_hold  <= next_req.hold_rsp;
      end
   end

   // Receiver: drives the result ready at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold--;
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         recv_hold = RSP_HOLD_LEN - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(1, 12) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Transfers on both channels are observed at the rising edge.
   always @(posedge clock) begin
      req_taken    = 1'b0;
      any_transfer = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               $error("result transfer with no request outstanding");
               error_count++;
            end else begin
               any_transfer = 1'b1;
               want = awaited_rsps.pop_front();
               if (rsp_out_value !== want.out_value) begin
                  $error("out_value: expected %0d, got %0d",
                         $signed(want.out_value), $signed(rsp_out_value));
                  error_count++;
               end
               if (rsp_out_valid !== want.out_valid) begin
                  $error("out_valid: expected %0d, got %0d", want.out_valid, rsp_out_valid);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            any_transfer = 1'b1;
            req_taken    = 1'b1;
            awaited_rsps.push_back(sorted_list_step(req_kind, req_value));
            if (req_hold) hold_asked++;
         end
         if (any_transfer) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      int seg_len;
      int enq_pct;
      int n;

      add_req(spq_pkg::KIND_DEQ, 32'sh7fff_ffff);
      add_req(spq_pkg::KIND_ENQ, 0);
      add_req(spq_pkg::KIND_ENQ, 32'sh7fff_ffff);
      add_req(spq_pkg::KIND_ENQ, 32'sh8000_0000);
      add_req(spq_pkg::KIND_ENQ, 0);
      add_req(spq_pkg::KIND_ENQ, -1);
      add_req(spq_pkg::KIND_ENQ, 1);
      add_req(spq_pkg::KIND_DEQ, 0);
      add_req(spq_pkg::KIND_DEQ, 32'sh8000_0000);
      add_req(spq_pkg::KIND_DEQ, -1);
      add_req(spq_pkg::KIND_DEQ, 32'sh5555_5555);
      add_req(spq_pkg::KIND_DEQ, 32'shaaaa_aaaa);
      add_req(spq_pkg::KIND_DEQ, 0);
      add_req(spq_pkg::KIND_DEQ, 0);

      while (pending_reqs.size() < RANDOM_TARGET) begin
         case ($urandom_range(0, 4))
            0: begin
               seg_len = CAPACITY + $urandom_range(1, 4);
               for (n = 0; n < seg_len; n++) add_req(spq_pkg::KIND_ENQ, pick_value());
               for (n = 0; n < seg_len; n++) add_req(spq_pkg::KIND_DEQ, pick_value());
               seg_len = 0;
            end
            1:       enq_pct = 80;
            2:       enq_pct = 25;
            3:       enq_pct = 50;
            default: enq_pct = 60;
         endcase
         seg_len = $urandom_range(10, 40);
         for (n = 0; n < seg_len; n++) begin
            if ($urandom_range(0, 99) < enq_pct) add_req(spq_pkg::KIND_ENQ, pick_value());
            else add_req(spq_pkg::KIND_DEQ, pick_value());
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[sorted_priority_queue_unit.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
verif/tb_top.sv
